@@ hw/rtl/sus_pkg.sv @@
package sus_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_SPARE  = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [KEY_W-1:0]  value;
  } in_beat_t;

  typedef struct packed {
    logic                     was_present;
    logic                     dropped_full;
    logic [4:0]               element_count;
    logic                     is_empty;
    logic signed [KEY_W-1:0]  smallest;
  } out_beat_t;

  // Broadcast to every cell for the beat being taken this cycle.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

@@ hw/rtl/sus_cell.sv @@
module sus_cell (
  input  logic                               clk,
  input  logic                               occupied,
  input  logic signed [sus_pkg::KEY_W-1:0]   key,
  input  sus_pkg::cell_ctl_t                 ctl,
  input  logic                               left_lt,
  input  logic signed [sus_pkg::KEY_W-1:0]   left_value,
  input  logic signed [sus_pkg::KEY_W-1:0]   right_value,
  output logic                               lt,
  output logic                               eq,
  output logic signed [sus_pkg::KEY_W-1:0]   value,
  output logic signed [sus_pkg::KEY_W-1:0]   value_nxt
);

  logic signed [sus_pkg::KEY_W-1:0] value_r;
  logic                             at_pos;

  assign lt     = occupied && (value_r < key);
  assign eq     = occupied && (value_r == key);
  // The first cell not below the key is where a new key lands.
  assign at_pos = !lt && left_lt;

  always_comb begin
    value_nxt = value_r;
    if (ctl.ins && !lt) begin
      value_nxt = at_pos ? key : left_value;
    end else if (ctl.rem && !lt) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

@@ hw/rtl/sorted_unique_set.sv @@
// Channel  | Ports                     | Handshake
// input    | start, busy, in_data      | beat taken when start is high and busy low
// result   | out_valid, out_data       | one beat per cycle strobe, cannot be held off
//
// One input beat is taken every cycle; busy never rises.
// Its result is registered and appears in the cycle after, as all cells compare the key at once
// and shift in the same cycle.
// A synchronous reset empties the set; stored keys are not cleared.
// There is no stall: the receiver must take each result when it is strobed.
module sorted_unique_set (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sus_pkg::in_beat_t   in_data,
  output logic                out_valid,
  output sus_pkg::out_beat_t  out_data
);

  localparam int N = sus_pkg::CAPACITY;

  logic [sus_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                              out_valid_r, out_valid_nxt;
  sus_pkg::out_beat_t                out_data_r, out_data_nxt;
  logic                              accept;
  logic                              present, full;
  sus_pkg::cell_ctl_t                ctl;
  logic [N-1:0]                      lt, eq, occ;
  logic signed [sus_pkg::KEY_W-1:0]  val      [N];
  logic signed [sus_pkg::KEY_W-1:0]  val_nxt  [N];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign occ[i] = sus_pkg::CNT_W'(i) < count_r;
    sus_cell u_cell (
      .clk         (clk),
      .occupied    (occ[i]),
      .key         (in_data.value),
      .ctl         (ctl),
      .left_lt     ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i-1]),
      .left_value  ((i == 0) ? in_data.value : val[(i == 0) ? 0 : i-1]),
      .right_value ((i == N-1) ? val[i] : val[(i == N-1) ? i : i+1]),
      .lt          (lt[i]),
      .eq          (eq[i]),
      .value       (val[i]),
      .value_nxt   (val_nxt[i])
    );
  end

  assign present = |eq;
  assign full    = (count_r == sus_pkg::CNT_W'(N));

  always_comb begin
    ctl.ins = accept && (in_data.action == sus_pkg::ACT_INSERT) && !present && !full;
    ctl.rem = accept && (in_data.action == sus_pkg::ACT_REMOVE) && present;

    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.rem) begin
      count_nxt = count_r - 1'b1;
    end

    out_valid_nxt              = accept;
    out_data_nxt.was_present   = present;
    out_data_nxt.dropped_full  = (in_data.action == sus_pkg::ACT_INSERT) && !present && full;
    out_data_nxt.element_count = 5'(count_nxt);
    out_data_nxt.is_empty      = (count_nxt == '0);
    out_data_nxt.smallest      = (count_nxt == '0) ? '0 : val_nxt[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/sus_checker.sv @@
module sus_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  sus_pkg::in_beat_t   in_data,
  input  logic                out_valid,
  input  sus_pkg::out_beat_t  out_data
);

  // Every beat taken yields exactly one result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an accepted beat");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.element_count == 5'd0)) &&
                  (!out_data.is_empty || out_data.smallest == '0))
    else $error("empty flag, count and smallest disagree");

  // A refused insert means the set was full and the key new.
  a_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.dropped_full) |->
      (out_data.element_count == 5'(sus_pkg::CAPACITY)) && !out_data.was_present)
    else $error("dropped insert while not full");

  a_drop_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.action != sus_pkg::ACT_INSERT)) |=>
      !out_data.dropped_full)
    else $error("dropped flag on a non-insert beat");

endmodule

bind sorted_unique_set sus_checker u_sus_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
